FILE: hdl/pci_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pci_pkg
// Shared widths, codes and saturation helpers of the perspective-correct
// attribute interpolator.
// ----------------------------------------------------------------------------
package pci_pkg;

    localparam int WIDE_W  = 128;
    localparam int SHORT_W = 17;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    localparam logic [1:0] NUM_VERTS = 2'd3;

    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_DEGEN      = 2'd1;
    localparam logic [1:0] STAT_ZERO_DEPTH = 2'd2;
    localparam logic [1:0] STAT_BAD_DEN    = 2'd3;

    typedef logic signed [WIDE_W-1:0]  wide_t;
    typedef logic signed [SHORT_W-1:0] short_t;
    typedef logic signed [63:0]        plane_t;

    function automatic plane_t sat64(input wide_t v);
        logic fits;
        fits = (&v[WIDE_W-1:63]) || !(|v[WIDE_W-1:63]);
        if (fits)
        begin
            return v[63:0];
        end
        return v[WIDE_W-1] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    endfunction

    function automatic logic [31:0] sat32(input wide_t v);
        logic fits;
        fits = (&v[WIDE_W-1:31]) || !(|v[WIDE_W-1:31]);
        if (fits)
        begin
            return v[31:0];
        end
        return v[WIDE_W-1] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
    endfunction

endpackage
`default_nettype wire

FILE: hdl/perspective_correct_interpolator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// perspective_correct_interpolator
// Triangle attribute interpolator with perspective correction, built on a
// bit-serial multiplier and a radix-2 divider under a step sequencer.
// ----------------------------------------------------------------------------
// A load word stores one vertex and then rebuilds the attribute/depth and
// 1/depth planes; it returns nothing and blocks input until setup is done.
// A full setup runs ten divisions on the shared divider (one quotient bit
// per cycle over 128 bits) and fourteen products on the serial multiplier
// (one bit of a 17-bit operand per cycle).
// An evaluate word returns one result word; with a valid setup it takes four
// products and, when the 1/depth sum is positive, one division. A
// finished result waits in an output register while the next word is taken.
module perspective_correct_interpolator #(
    parameter int COORD_FRAC_BITS = 4,
    parameter int ATTR_FRAC_BITS  = 16,
    parameter int PLANE_FRAC_BITS = 32
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_tvalid,
    output logic         s_tready,
    // vertex_index[1:0], coord_x[17:2], coord_y[33:18], depth[65:34],
    // attribute[97:66], zero fill up to bit 103
    input  wire  [103:0] s_tdata,
    // action[0]
    input  wire  [0:0]   s_tuser,
    output logic         m_tvalid,
    input  wire          m_tready,
    // value[31:0]
    output logic [31:0]  m_tdata,
    // status[1:0]
    output logic [1:0]   m_tuser
);
    import pci_pkg::*;

    localparam int DET_W = 36;
    localparam wide_t RECIP_ONE = wide_t'(1) <<< (ATTR_FRAC_BITS + PLANE_FRAC_BITS);

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_DELTA  = 5'd1;
    localparam logic [4:0] ST_DET_AD = 5'd2;
    localparam logic [4:0] ST_DET_BC = 5'd3;
    localparam logic [4:0] ST_CHECK  = 5'd4;
    localparam logic [4:0] ST_RECIP  = 5'd5;
    localparam logic [4:0] ST_PX_ED  = 5'd6;
    localparam logic [4:0] ST_PX_FB  = 5'd7;
    localparam logic [4:0] ST_PX_DIV = 5'd8;
    localparam logic [4:0] ST_PY_FA  = 5'd9;
    localparam logic [4:0] ST_PY_EC  = 5'd10;
    localparam logic [4:0] ST_PY_DIV = 5'd11;
    localparam logic [4:0] ST_PO_SET = 5'd12;
    localparam logic [4:0] ST_PO_X   = 5'd13;
    localparam logic [4:0] ST_PO_Y   = 5'd14;
    localparam logic [4:0] ST_PO_WR  = 5'd15;
    localparam logic [4:0] ST_EV_SET = 5'd16;
    localparam logic [4:0] ST_EV_X   = 5'd17;
    localparam logic [4:0] ST_EV_Y   = 5'd18;
    localparam logic [4:0] ST_EV_WR  = 5'd19;
    localparam logic [4:0] ST_EV_DIV = 5'd20;
    localparam logic [4:0] ST_EMIT   = 5'd21;

    localparam logic [1:0] ACC_SET = 2'd0;
    localparam logic [1:0] ACC_ADD = 2'd1;
    localparam logic [1:0] ACC_SUB = 2'd2;

    logic [4:0]   state_reg;
    logic         pend_reg;
    logic [31:0]  vxy_reg  [3];
    logic [31:0]  vdep_reg [3];
    logic [31:0]  vatt_reg [3];
    short_t       da_reg, db_reg, dc_reg, dd_reg;
    logic signed [DET_W-1:0] det_reg;
    plane_t       u_reg [3];
    plane_t       w_reg [3];
    plane_t       gx_reg [2];
    plane_t       gy_reg [2];
    plane_t       org_reg [2];
    logic [2:0]   kcnt_reg;
    logic         plane_reg;
    wide_t        acc_reg;
    wide_t        pa_reg;
    logic [1:0]   status_reg;
    logic [31:0]  res_value_reg;
    logic [1:0]   res_status_reg;
    logic         out_valid_reg;
    logic [31:0]  out_value_reg;
    logic [1:0]   out_status_reg;

    logic         in_accept;
    logic         in_action;
    logic [1:0]   in_vidx;
    logic [15:0]  in_x, in_y;
    logic [31:0]  in_depth, in_attr;
    logic signed [15:0] px_reg, py_reg;

    logic         is_mul, is_div;
    logic [1:0]   acc_mode;
    wide_t        mul_w, mul_prod, div_num, div_den, div_q;
    short_t       mul_s;
    logic         mul_start, mul_done, div_start, div_done;
    logic [1:0]   vi;
    plane_t       pv0, pv1, pv2;
    wide_t        e_w, f_w, acc_shr, mac_sum;
    logic         any_zero_depth;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = state_reg == ST_IDLE;
    assign in_action = s_tuser[0];
    assign in_vidx   = s_tdata[1:0];
    assign in_x      = s_tdata[17:2];
    assign in_y      = s_tdata[33:18];
    assign in_depth  = s_tdata[65:34];
    assign in_attr   = s_tdata[97:66];

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_status_reg;

    assign vi  = kcnt_reg[2:1];
    assign pv0 = plane_reg ? w_reg[0] : u_reg[0];
    assign pv1 = plane_reg ? w_reg[1] : u_reg[1];
    assign pv2 = plane_reg ? w_reg[2] : u_reg[2];
    assign e_w = wide_t'(pv1) - wide_t'(pv0);
    assign f_w = wide_t'(pv2) - wide_t'(pv0);
    assign acc_shr = acc_reg >>> COORD_FRAC_BITS;
    assign any_zero_depth = (vdep_reg[0] == '0) || (vdep_reg[1] == '0)
                            || (vdep_reg[2] == '0);

    always_comb
    begin
        is_mul   = 1'b0;
        is_div   = 1'b0;
        acc_mode = ACC_SET;
        mul_w    = '0;
        mul_s    = '0;
        div_num  = '0;
        div_den  = '0;
        unique case (state_reg)
            ST_DET_AD:
            begin
                is_mul = 1'b1;
                mul_w  = wide_t'(da_reg);
                mul_s  = dd_reg;
            end
            ST_DET_BC:
            begin
                is_mul   = 1'b1;
                acc_mode = ACC_SUB;
                mul_w    = wide_t'(db_reg);
                mul_s    = dc_reg;
            end
            ST_PX_ED:
            begin
                is_mul = 1'b1;
                mul_w  = e_w;
                mul_s  = dd_reg;
            end
            ST_PX_FB:
            begin
                is_mul   = 1'b1;
                acc_mode = ACC_SUB;
                mul_w    = f_w;
                mul_s    = db_reg;
            end
            ST_PY_FA:
            begin
                is_mul = 1'b1;
                mul_w  = f_w;
                mul_s  = da_reg;
            end
            ST_PY_EC:
            begin
                is_mul   = 1'b1;
                acc_mode = ACC_SUB;
                mul_w    = e_w;
                mul_s    = dc_reg;
            end
            ST_PO_X:
            begin
                is_mul   = 1'b1;
                acc_mode = ACC_SUB;
                mul_w    = wide_t'(gx_reg[plane_reg]);
                mul_s    = short_t'($signed(vxy_reg[0][15:0]));
            end
            ST_PO_Y:
            begin
                is_mul   = 1'b1;
                acc_mode = ACC_SUB;
                mul_w    = wide_t'(gy_reg[plane_reg]);
                mul_s    = short_t'($signed(vxy_reg[0][31:16]));
            end
            ST_EV_X:
            begin
                is_mul   = 1'b1;
                acc_mode = ACC_ADD;
                mul_w    = wide_t'(gx_reg[plane_reg]);
                mul_s    = short_t'(px_reg);
            end
            ST_EV_Y:
            begin
                is_mul   = 1'b1;
                acc_mode = ACC_ADD;
                mul_w    = wide_t'(gy_reg[plane_reg]);
                mul_s    = short_t'(py_reg);
            end
            ST_RECIP:
            begin
                is_div  = 1'b1;
                div_num = kcnt_reg[0] ? RECIP_ONE
                        : wide_t'($signed(vatt_reg[vi])) <<< PLANE_FRAC_BITS;
                div_den = wide_t'(vdep_reg[vi]);
            end
            ST_PX_DIV, ST_PY_DIV:
            begin
                is_div  = 1'b1;
                div_num = acc_reg <<< COORD_FRAC_BITS;
                div_den = wide_t'(det_reg);
            end
            ST_EV_DIV:
            begin
                is_div  = 1'b1;
                div_num = pa_reg <<< ATTR_FRAC_BITS;
                div_den = acc_shr;
            end
            default:
            begin
                is_mul = 1'b0;
            end
        endcase
    end

    assign mul_start = is_mul && !pend_reg;
    assign div_start = is_div && !pend_reg;

    always_comb
    begin
        case (acc_mode)
            ACC_ADD: mac_sum = acc_reg + mul_prod;
            ACC_SUB: mac_sum = acc_reg - mul_prod;
            default: mac_sum = mul_prod;
        endcase
    end

    pci_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .w       (mul_w),
        .s       (mul_s),
        .done    (mul_done),
        .product (mul_prod)
    );

    pci_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            status_reg    <= STAT_DEGEN;
            kcnt_reg      <= '0;
            plane_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                vxy_reg[i]  <= '0;
                vdep_reg[i] <= '0;
                vatt_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (mul_start || div_start)
            begin
                pend_reg <= 1'b1;
            end
            if (mul_done || div_done)
            begin
                pend_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        if (in_action == ACT_LOAD)
                        begin
                            if (in_vidx < NUM_VERTS)
                            begin
                                vxy_reg[in_vidx]  <= {in_y, in_x};
                                vdep_reg[in_vidx] <= in_depth;
                                vatt_reg[in_vidx] <= in_attr;
                                state_reg         <= ST_DELTA;
                            end
                        end
                        else if (status_reg != STAT_OK)
                        begin
                            state_reg <= ST_EMIT;
                        end
                        else
                        begin
                            plane_reg <= 1'b0;
                            state_reg <= ST_EV_SET;
                        end
                    end
                end
                ST_DELTA:  state_reg <= ST_DET_AD;
                ST_DET_AD: if (mul_done) state_reg <= ST_DET_BC;
                ST_DET_BC: if (mul_done) state_reg <= ST_CHECK;
                ST_CHECK:
                begin
                    if (acc_reg == '0)
                    begin
                        status_reg <= STAT_DEGEN;
                        state_reg  <= ST_IDLE;
                    end
                    else if (any_zero_depth)
                    begin
                        status_reg <= STAT_ZERO_DEPTH;
                        state_reg  <= ST_IDLE;
                    end
                    else
                    begin
                        kcnt_reg  <= '0;
                        state_reg <= ST_RECIP;
                    end
                end
                ST_RECIP:
                begin
                    if (div_done)
                    begin
                        if (kcnt_reg == 3'd5)
                        begin
                            plane_reg <= 1'b0;
                            state_reg <= ST_PX_ED;
                        end
                        else
                        begin
                            kcnt_reg <= kcnt_reg + 1'b1;
                        end
                    end
                end
                ST_PX_ED:  if (mul_done) state_reg <= ST_PX_FB;
                ST_PX_FB:  if (mul_done) state_reg <= ST_PX_DIV;
                ST_PX_DIV: if (div_done) state_reg <= ST_PY_FA;
                ST_PY_FA:  if (mul_done) state_reg <= ST_PY_EC;
                ST_PY_EC:  if (mul_done) state_reg <= ST_PY_DIV;
                ST_PY_DIV: if (div_done) state_reg <= ST_PO_SET;
                ST_PO_SET: state_reg <= ST_PO_X;
                ST_PO_X:   if (mul_done) state_reg <= ST_PO_Y;
                ST_PO_Y:   if (mul_done) state_reg <= ST_PO_WR;
                ST_PO_WR:
                begin
                    if (!plane_reg)
                    begin
                        plane_reg <= 1'b1;
                        state_reg <= ST_PX_ED;
                    end
                    else
                    begin
                        status_reg <= STAT_OK;
                        state_reg  <= ST_IDLE;
                    end
                end
                ST_EV_SET: state_reg <= ST_EV_X;
                ST_EV_X:   if (mul_done) state_reg <= ST_EV_Y;
                ST_EV_Y:   if (mul_done) state_reg <= ST_EV_WR;
                ST_EV_WR:
                begin
                    if (!plane_reg)
                    begin
                        plane_reg <= 1'b1;
                        state_reg <= ST_EV_SET;
                    end
                    else if (acc_shr[WIDE_W-1] || acc_shr == '0)
                    begin
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        state_reg <= ST_EV_DIV;
                    end
                end
                ST_EV_DIV: if (div_done) state_reg <= ST_EMIT;
                ST_EMIT:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && in_action == ACT_EVAL)
        begin
            px_reg         <= $signed(in_x);
            py_reg         <= $signed(in_y);
            res_value_reg  <= '0;
            res_status_reg <= status_reg;
        end
        if (state_reg == ST_DELTA)
        begin
            da_reg <= short_t'($signed(vxy_reg[1][15:0])) - short_t'($signed(vxy_reg[0][15:0]));
            db_reg <= short_t'($signed(vxy_reg[1][31:16]))
                      - short_t'($signed(vxy_reg[0][31:16]));
            dc_reg <= short_t'($signed(vxy_reg[2][15:0])) - short_t'($signed(vxy_reg[0][15:0]));
            dd_reg <= short_t'($signed(vxy_reg[2][31:16]))
                      - short_t'($signed(vxy_reg[0][31:16]));
        end
        if (is_mul && mul_done)
        begin
            acc_reg <= mac_sum;
        end
        if (state_reg == ST_CHECK)
        begin
            det_reg <= acc_reg[DET_W-1:0];
        end
        if (state_reg == ST_RECIP && div_done)
        begin
            if (kcnt_reg[0])
            begin
                w_reg[vi] <= sat64(div_q);
            end
            else
            begin
                u_reg[vi] <= sat64(div_q);
            end
        end
        if (state_reg == ST_PX_DIV && div_done)
        begin
            gx_reg[plane_reg] <= sat64(div_q);
        end
        if (state_reg == ST_PY_DIV && div_done)
        begin
            gy_reg[plane_reg] <= sat64(div_q);
        end
        if (state_reg == ST_PO_SET)
        begin
            acc_reg <= wide_t'(pv0) <<< COORD_FRAC_BITS;
        end
        if (state_reg == ST_PO_WR)
        begin
            org_reg[plane_reg] <= sat64(acc_shr);
        end
        if (state_reg == ST_EV_SET)
        begin
            acc_reg <= wide_t'(org_reg[plane_reg]) <<< COORD_FRAC_BITS;
        end
        if (state_reg == ST_EV_WR)
        begin
            if (!plane_reg)
            begin
                pa_reg <= acc_shr;
            end
            else
            begin
                res_value_reg  <= '0;
                res_status_reg <= STAT_BAD_DEN;
            end
        end
        if (state_reg == ST_EV_DIV && div_done)
        begin
            res_value_reg  <= sat32(div_q);
            res_status_reg <= STAT_OK;
        end
        if (state_reg == ST_EMIT && (!out_valid_reg || m_tready))
        begin
            out_value_reg  <= res_value_reg;
            out_status_reg <= res_status_reg;
        end
    end

    // A new result word only ever appears from the emit step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_EMIT))
        else $error("result word raised outside the emit step");

    // The setup status never holds the bad denominator code.
    assert property (@(posedge clk) disable iff (!rst_n)
        status_reg != STAT_BAD_DEN)
        else $error("setup status holds bad denominator code");

    // The reciprocal loop covers three vertices, two quotients each.
    assert property (@(posedge clk) disable iff (!rst_n)
        kcnt_reg <= 3'd5)
        else $error("reciprocal counter out of range");

    // The multiplier and the divider are never started together.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_start && div_start))
        else $error("both arithmetic units started at once");

endmodule
`default_nettype wire

FILE: hdl/pci_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pci_mul
// Bit-serial signed multiplier: a wide operand times a short operand, one
// bit of the short operand per cycle, product modulo the wide width.
// ----------------------------------------------------------------------------
module pci_mul (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    input  pci_pkg::wide_t      w,
    input  pci_pkg::short_t     s,
    output logic                done,
    output pci_pkg::wide_t      product
);
    import pci_pkg::*;

    localparam int CNT_W = $clog2(SHORT_W + 1);

    wide_t              mcand_reg;
    wide_t              prod_reg;
    logic [SHORT_W-1:0] mplier_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    wide_t              term;
    logic               last;

    assign last    = cnt_reg == CNT_W'(SHORT_W - 1);
    assign term    = mplier_reg[0] ? mcand_reg : '0;
    assign done    = done_reg;
    assign product = prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= w;
            mplier_reg <= s;
            prod_reg   <= '0;
        end
        else if (busy_reg)
        begin
            // The top bit of the short operand carries negative weight.
            prod_reg   <= last ? prod_reg - term : prod_reg + term;
            mcand_reg  <= mcand_reg <<< 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/pci_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pci_div
// Radix-2 restoring signed divider, one quotient bit per cycle, quotient
// truncated toward zero.
// ----------------------------------------------------------------------------
module pci_div (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    input  pci_pkg::wide_t      num,
    input  pci_pkg::wide_t      den,
    output logic                done,
    output pci_pkg::wide_t      quotient
);
    import pci_pkg::*;

    localparam int CNT_W = $clog2(WIDE_W + 1);

    logic [WIDE_W:0]   rem_reg;
    logic [WIDE_W-1:0] quo_reg;
    logic [WIDE_W-1:0] den_reg;
    logic              neg_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [WIDE_W:0]   shifted;
    logic [WIDE_W+1:0] diff;
    logic              ge;
    logic              last;

    assign shifted  = {rem_reg[WIDE_W-1:0], quo_reg[WIDE_W-1]};
    assign diff     = {1'b0, shifted} - {2'b0, den_reg};
    assign ge       = !diff[WIDE_W+1];
    assign last     = cnt_reg == CNT_W'(WIDE_W - 1);
    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num[WIDE_W-1] ? -num : num;
            den_reg <= den[WIDE_W-1] ? -den : den;
            neg_reg <= num[WIDE_W-1] ^ den[WIDE_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[WIDE_W:0] : shifted;
            quo_reg <= {quo_reg[WIDE_W-2:0], ge};
        end
    end

endmodule
`default_nettype wire
